// File: rtl/core/jse_pkg.sv
`default_nettype none
package jse_pkg;

   localparam int unsigned FILL_W       = 16;
   localparam logic [FILL_W-1:0] CAPACITY_RESET = 16'hFFFF;

   // Queue depth must be a power of two so the pointers wrap naturally.
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned IDX_W        = 4;

   localparam logic [2:0] CMD_BODY     = 3'd0;
   localparam logic [2:0] CMD_BEGIN    = 3'd1;
   localparam logic [2:0] CMD_BOUNDARY = 3'd2;
   localparam logic [2:0] CMD_END      = 3'd3;
   localparam logic [2:0] CMD_CLEAR    = 3'd4;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [IDX_W-1:0] LEN_PLAIN = 4'd1;
   localparam logic [IDX_W-1:0] LEN_PAIR  = 4'd2;
   localparam logic [IDX_W-1:0] LEN_UNI   = 4'd6;
   localparam logic [IDX_W-1:0] LEN_SEP   = 4'd4;

   typedef enum logic [1:0] {
      JOB_BODY  = 2'd0,
      JOB_BEGIN = 2'd1,
      JOB_END   = 2'd2,
      JOB_CLEAR = 2'd3
   } job_kind_type;

   typedef enum logic [1:0] {
      ESC_PLAIN = 2'd0,
      ESC_PAIR  = 2'd1,
      ESC_UNI   = 2'd2
   } esc_type;

   typedef struct packed {
      job_kind_type kind;
      logic         sep;
      esc_type      esc;
      logic [7:0]   ch;
   } job_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              out_valid;
      logic [FILL_W-1:0] position;
      logic              last;
      logic              overflow;
      logic              result_code;
   } rsp_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = 8'h30 + {4'b0000, d};
      end else begin
         r = 8'h57 + {4'b0000, d};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/jse_front.sv
`default_nettype none
module jse_front
   import jse_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      push_job
);

   logic part_has_bytes_ff, part_has_bytes_in;
   logic sep_pending_ff, sep_pending_in;
   logic accept;
   logic has_job;

   assign req_ready = ~queue_full;
   assign accept    = req_valid & req_ready;
   assign push      = accept & has_job;

   always_comb begin
      part_has_bytes_in = part_has_bytes_ff;
      sep_pending_in    = sep_pending_ff;
      has_job           = 1'b0;
      push_job.kind     = JOB_BODY;
      push_job.sep      = 1'b0;
      push_job.esc      = ESC_PLAIN;
      push_job.ch       = req_data.in_byte;
      case (req_data.in_byte)
         CH_QUOTE: begin
            push_job.esc = ESC_PAIR;
         end
         CH_BSLASH: begin
            push_job.esc = ESC_PAIR;
         end
         CH_LF: begin
            push_job.esc = ESC_PAIR;
            push_job.ch  = CH_N;
         end
         CH_CR: begin
            push_job.esc = ESC_PAIR;
            push_job.ch  = CH_R;
         end
         CH_TAB: begin
            push_job.esc = ESC_PAIR;
            push_job.ch  = CH_T;
         end
         default: begin
            if (req_data.in_byte < CTRL_LIMIT) begin
               push_job.esc = ESC_UNI;
            end
         end
      endcase
      case (req_data.cmd)
         CMD_BODY: begin
            has_job           = 1'b1;
            push_job.sep      = sep_pending_ff;
            part_has_bytes_in = 1'b1;
            sep_pending_in    = 1'b0;
         end
         CMD_BEGIN: begin
            has_job           = 1'b1;
            push_job.kind     = JOB_BEGIN;
            part_has_bytes_in = 1'b0;
            sep_pending_in    = 1'b0;
         end
         CMD_BOUNDARY: begin
            sep_pending_in    = sep_pending_ff | part_has_bytes_ff;
            part_has_bytes_in = 1'b0;
         end
         CMD_END: begin
            has_job           = 1'b1;
            push_job.kind     = JOB_END;
            part_has_bytes_in = 1'b0;
            sep_pending_in    = 1'b0;
         end
         CMD_CLEAR: begin
            has_job           = 1'b1;
            push_job.kind     = JOB_CLEAR;
            part_has_bytes_in = 1'b0;
            sep_pending_in    = 1'b0;
         end
         default: begin
            has_job = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_has_bytes_ff <= 1'b0;
         sep_pending_ff    <= 1'b0;
      end else if (accept) begin
         part_has_bytes_ff <= part_has_bytes_in;
         sep_pending_ff    <= sep_pending_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/jse_queue.sv
`default_nettype none
module jse_queue
   import jse_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      count_in = count_ff;
      if (push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/jse_back.sv
`default_nettype none
module jse_back
   import jse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [FILL_W-1:0] capacity,
   input  wire logic              head_valid,
   input  wire job_type           head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data
);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              overflow_ff, overflow_in;
   logic              trunc_ff, trunc_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              advance;
   logic              emit;
   logic              store;
   logic              last_char;
   logic [IDX_W-1:0]  esc_len;
   logic [IDX_W-1:0]  total;
   logic [IDX_W-1:0]  k;
   logic [7:0]        ch;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign advance   = head_valid & (~rsp_valid_ff | rsp_ready);
   assign emit      = advance & (head_job.kind != JOB_CLEAR);
   assign store     = ({1'b0, fill_ff} + 17'd1) < {1'b0, capacity};

   always_comb begin
      case (head_job.esc)
         ESC_PAIR: esc_len = LEN_PAIR;
         ESC_UNI:  esc_len = LEN_UNI;
         default:  esc_len = LEN_PLAIN;
      endcase
      if (head_job.kind == JOB_BODY) begin
         total = (head_job.sep ? LEN_SEP : '0) + esc_len;
      end else begin
         total = LEN_PLAIN;
      end
      last_char = (idx_ff == total - 1'b1);
      k = idx_ff - (head_job.sep ? LEN_SEP : '0);

      // The separator comes out as backslash, n, backslash, n.
      ch = CH_QUOTE;
      if (head_job.kind == JOB_BODY) begin
         if (head_job.sep && (idx_ff < LEN_SEP)) begin
            ch = idx_ff[0] ? CH_N : CH_BSLASH;
         end else begin
            case (head_job.esc)
               ESC_PAIR: begin
                  ch = (k == '0) ? CH_BSLASH : head_job.ch;
               end
               ESC_UNI: begin
                  case (k[2:0])
                     3'd0:    ch = CH_BSLASH;
                     3'd1:    ch = CH_U;
                     3'd2:    ch = CH_ZERO;
                     3'd3:    ch = CH_ZERO;
                     3'd4:    ch = hex_char(head_job.ch[7:4]);
                     default: ch = hex_char(head_job.ch[3:0]);
                  endcase
               end
               default: begin
                  ch = head_job.ch;
               end
            endcase
         end
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      overflow_in = overflow_ff;
      trunc_in    = trunc_ff;
      idx_in      = idx_ff;
      pop         = 1'b0;
      if (advance) begin
         if (head_job.kind == JOB_CLEAR) begin
            fill_in     = '0;
            overflow_in = 1'b0;
            trunc_in    = 1'b0;
            idx_in      = '0;
            pop         = 1'b1;
         end else begin
            // A begin clears the truncation mark before its quote is written.
            trunc_in = (head_job.kind == JOB_BEGIN) ? 1'b0 : trunc_ff;
            if (store) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
               trunc_in    = 1'b1;
            end
            pop    = last_char;
            idx_in = last_char ? '0 : idx_ff + 1'b1;
         end
      end
      rsp_data_in.out_byte    = ch;
      rsp_data_in.out_valid   = store;
      rsp_data_in.position    = fill_ff;
      rsp_data_in.last        = last_char;
      rsp_data_in.overflow    = overflow_in;
      rsp_data_in.result_code = (head_job.kind == JOB_END) ? trunc_in : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         trunc_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         overflow_ff <= overflow_in;
         trunc_ff    <= trunc_in;
         idx_ff      <= idx_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/json_string_escape_bounded.sv
// JSON string escaper with a bounded output buffer.
// Input channel req_*: one command per transfer (body byte, begin, part boundary,
// end, clear). Result channel rsp_*: one character per transfer, with its buffer
// position, a stored/dropped bit, the sticky overflow flag and, on the closing
// quote, the truncation code; last marks the final character of a command.
// The csr_* port writes the buffer capacity; write it only while the block is idle.
// A front stage classifies commands and tracks part separators, a four-entry
// queue decouples it from the back stage, which expands each command into
// characters and keeps the fill level.
// The first character of a command is offered after it has passed through the
// queue and the result register. Throughput: one character per cycle while the
// receiver holds rsp_ready high; a command expands to 1 to 10 characters (6 for
// a \u00xx escape, 4 more when a separator is pending); clear gives none.
// Part boundaries and unused codes never enter the queue.
// While the receiver stalls, the result register holds; the queue keeps taking
// commands until it fills, then req_ready drops.
// Reset empties the queue, zeroes all control state and sets capacity to 65535.
`default_nettype none
module json_string_escape_bounded
   import jse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_write,
   input  wire logic [FILL_W-1:0] csr_data
);

   logic [FILL_W-1:0] capacity_ff;
   logic              queue_full;
   logic              push;
   job_type           push_job;
   logic              pop;
   logic              head_valid;
   job_type           head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write) begin
         capacity_ff <= csr_data;
      end
   end

   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   jse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
